[src/hmmf_pkg.sv]
// ---------------------------------------------------------------------------
// hmmf_pkg
// Shared types and constants for the HMM forward filter predictor.
// ---------------------------------------------------------------------------
package hmmf_pkg;

  localparam logic [2:0] OP_WR_TRANS  = 3'd0;
  localparam logic [2:0] OP_WR_EMIS   = 3'd1;
  localparam logic [2:0] OP_WR_INIT   = 3'd2;
  localparam logic [2:0] OP_RESTART   = 3'd3;
  localparam logic [2:0] OP_OBSERVE   = 3'd4;

  localparam logic [15:0] WARMUP_RESET = 16'd100;
  localparam int unsigned QBITS        = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } hmmf_state_t;

  typedef enum logic [1:0] {
    PH_HID,
    PH_SYM,
    PH_NUM
  } hmmf_phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hmmf_div_stat_t;

endpackage

[src/hmmf_if.sv]
// ---------------------------------------------------------------------------
// hmmf_if
// Valid/ready channels of the HMM forward filter predictor.
// ---------------------------------------------------------------------------
interface hmmf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] row_index;
  logic [3:0] column_index;
  logic [15:0] prob_value;
  logic [3:0] observed_symbol;
  modport source (output valid, opcode, row_index, column_index, prob_value,
                  observed_symbol, input ready);
  modport sink (input valid, opcode, row_index, column_index, prob_value,
                observed_symbol, output ready);
endinterface

interface hmmf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] predicted_symbol;
  logic       scored;
  logic       hit;
  logic       direction_counted;
  logic       direction_agree;
  logic       impossible;
  modport source (output valid, predicted_symbol, scored, hit, direction_counted,
                  direction_agree, impossible, input ready);
  modport sink (input valid, predicted_symbol, scored, hit, direction_counted,
                direction_agree, impossible, output ready);
endinterface

interface hmmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/hmmf_frac_div.sv]
// ---------------------------------------------------------------------------
// hmmf_frac_div
// Restoring divider: quot = floor(num * 2^15 / den), num <= den, den != 0.
// ---------------------------------------------------------------------------
module hmmf_frac_div
  import hmmf_pkg::*;
#(
  parameter int NW = 51,
  parameter int TW = 54
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [TW-1:0]        den,
  output hmmf_div_stat_t       stat,
  output logic [QBITS-1:0]     quot
);

  logic [TW:0]          rem_r, rem_nxt, rem_sh;
  logic [QBITS-1:0]     q_r, q_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [TW:0]          num_x, den_x;

  assign num_x  = (TW+1)'(num);
  assign den_x  = {1'b0, den};
  assign rem_sh = {rem_r[TW-1:0], 1'b0};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'(QBITS - 1);
      if (num_x >= den_x) begin
        q_nxt   = QBITS'(1);
        rem_nxt = num_x - den_x;
      end else begin
        q_nxt   = '0;
        rem_nxt = num_x;
      end
    end else if (busy_r) begin
      if (rem_sh >= den_x) begin
        rem_nxt = rem_sh - den_x;
        q_nxt   = {q_r[QBITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[QBITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

[src/hmm_forward_filter_predictor.sv]
// ---------------------------------------------------------------------------
// hmm_forward_filter_predictor
// HMM forward filter with next-symbol prediction over table memories.
// ---------------------------------------------------------------------------
//  channel | dir | contents
//  in_ch   | in  | opcode, row_index, column_index, prob_value, observed_symbol
//  out_ch  | out | predicted_symbol, scored, hit, direction_*, impossible
//  cfg_ch  | in  | warmup_count
//
//  Restart copies the initial probabilities into the belief memory.
//  Observe: S*S + S*K + S multiply-accumulates, each read, multiplied
//  and accumulated through the one shared multiplier, then a divide per state.
//  rst_n is synchronous; belief reads as zero until written.
//  An item is taken only while idle and the output slot is free or being drained.
// ---------------------------------------------------------------------------
module hmm_forward_filter_predictor
  import hmmf_pkg::*;
#(
  parameter int NUM_STATES  = 6,
  parameter int NUM_SYMBOLS = 11,
  parameter int PROB_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  hmmf_in_if.sink    in_ch,
  hmmf_out_if.source out_ch,
  hmmf_cfg_if.sink   cfg_ch
);

  localparam int PW   = (PROB_BITS < 16) ? PROB_BITS : 16;
  localparam int SW   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int KW   = $clog2(NUM_SYMBOLS);
  localparam int OW   = (SW > KW) ? SW : KW;
  localparam int HW   = QBITS + PW + SW;
  localparam int MW   = HW + PW;
  localparam int TW   = MW + SW;
  localparam int TAW  = $clog2(NUM_STATES * NUM_STATES);
  localparam int EAW  = $clog2(NUM_STATES * NUM_SYMBOLS);
  localparam int HALF = NUM_SYMBOLS / 2;

  logic [PW-1:0]    tr_mem   [NUM_STATES*NUM_STATES];
  logic [PW-1:0]    em_mem   [NUM_STATES*NUM_SYMBOLS];
  logic [PW-1:0]    init_mem [NUM_STATES];
  logic [QBITS-1:0] bel_mem  [NUM_STATES];
  logic [HW-1:0]    hid_mem  [NUM_STATES];
  logic [MW-1:0]    num_mem  [NUM_STATES];
  logic [NUM_STATES-1:0] bel_vld_r;

  logic [PW-1:0]    tr_rd_r, em_rd_r, init_rd_r;
  logic [QBITS-1:0] bel_rd_r;
  logic             bel_vrd_r;
  logic [HW-1:0]    hid_rd_r;
  logic [MW-1:0]    num_rd_r;

  hmmf_state_t st_r, st_nxt;
  hmmf_phase_t ph_r, ph_nxt;
  logic [SW-1:0] n_r, n_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic [TW-1:0] acc_r, acc_nxt, acc_sum;
  logic [MW-1:0] prod_r;
  logic [TW-1:0] best_r, best_nxt;
  logic [3:0]    guess_r, guess_nxt;
  logic [3:0]    obs_r;
  logic          obs_ok_r, is_obs_r, scored_r, imp_r, imp_nxt;
  logic [15:0]   cnt_r, warm_r;

  logic [TAW-1:0] tr_ra, tr_wa;
  logic [EAW-1:0] em_ra, em_wa;
  logic [OW-1:0]  esel;
  logic [HW-1:0]  mx;
  logic [PW-1:0]  my;

  logic in_fire, out_free, hid_we, num_we, bel_we, div_start;
  logic [QBITS-1:0] bel_wd, quot;
  hmmf_div_stat_t   div_stat;

  logic [3:0] g_out;
  logic       hit_c, cnt_c, agr_c;

  assign out_free     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = (st_r == ST_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign esel  = (ph_r == PH_NUM) ? OW'(obs_r) : o_r;
  assign tr_ra = TAW'(int'(n_r) * NUM_STATES + int'(o_r));
  assign em_ra = EAW'(int'(n_r) * NUM_SYMBOLS + int'(esel));
  assign tr_wa = TAW'(int'(in_ch.row_index) * NUM_STATES + int'(in_ch.column_index));
  assign em_wa = EAW'(int'(in_ch.row_index) * NUM_SYMBOLS + int'(in_ch.column_index));

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.opcode == OP_WR_TRANS && int'(in_ch.row_index) < NUM_STATES &&
        int'(in_ch.column_index) < NUM_STATES) begin
      tr_mem[tr_wa] <= in_ch.prob_value[PW-1:0];
    end
    if (in_fire && in_ch.opcode == OP_WR_EMIS && int'(in_ch.row_index) < NUM_STATES &&
        int'(in_ch.column_index) < NUM_SYMBOLS) begin
      em_mem[em_wa] <= in_ch.prob_value[PW-1:0];
    end
    if (in_fire && in_ch.opcode == OP_WR_INIT && int'(in_ch.row_index) < NUM_STATES) begin
      init_mem[in_ch.row_index[SW-1:0]] <= in_ch.prob_value[PW-1:0];
    end
    if (hid_we) begin
      hid_mem[o_r[SW-1:0]] <= acc_sum[HW-1:0];
    end
    if (num_we) begin
      num_mem[n_r] <= prod_r;
    end
    if (bel_we) begin
      bel_mem[n_r] <= bel_wd;
    end
    tr_rd_r   <= tr_mem[tr_ra];
    em_rd_r   <= em_mem[em_ra];
    init_rd_r <= init_mem[n_r];
    bel_rd_r  <= bel_mem[n_r];
    bel_vrd_r <= bel_vld_r[n_r];
    hid_rd_r  <= hid_mem[n_r];
    num_rd_r  <= num_mem[n_r];
  end

  assign mx = (ph_r == PH_HID) ? (bel_vrd_r ? HW'(bel_rd_r) : '0) : hid_rd_r;
  assign my = (ph_r == PH_HID) ? tr_rd_r : ((ph_r == PH_NUM && !obs_ok_r) ? '0 : em_rd_r);
  assign acc_sum = acc_r + TW'(prod_r);

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    n_nxt     = n_r;
    o_nxt     = o_r;
    acc_nxt   = acc_r;
    best_nxt  = best_r;
    guess_nxt = guess_r;
    imp_nxt   = imp_r;
    hid_we    = 1'b0;
    num_we    = 1'b0;
    bel_we    = 1'b0;
    bel_wd    = quot;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        n_nxt   = '0;
        o_nxt   = '0;
        acc_nxt = '0;
        ph_nxt  = PH_HID;
        imp_nxt = 1'b0;
        if (in_fire && in_ch.opcode == OP_RESTART) begin
          st_nxt = ST_COPY_RD;
        end else if (in_fire && in_ch.opcode == OP_OBSERVE) begin
          st_nxt = ST_RD;
        end
      end
      ST_COPY_RD: st_nxt = ST_COPY_WR;
      ST_COPY_WR: begin
        bel_we = 1'b1;
        bel_wd = QBITS'(init_rd_r);
        if (n_r == SW'(NUM_STATES - 1)) begin
          st_nxt = ST_DONE;
        end else begin
          n_nxt  = n_r + SW'(1);
          st_nxt = ST_COPY_RD;
        end
      end
      ST_RD: st_nxt = ST_MUL;
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: begin
        st_nxt  = ST_RD;
        acc_nxt = acc_sum;
        n_nxt   = n_r + SW'(1);
        case (ph_r)
          PH_HID: begin
            if (n_r == SW'(NUM_STATES - 1)) begin
              hid_we  = 1'b1;
              acc_nxt = '0;
              n_nxt   = '0;
              if (o_r == OW'(NUM_STATES - 1)) begin
                o_nxt  = '0;
                ph_nxt = PH_SYM;
              end else begin
                o_nxt = o_r + OW'(1);
              end
            end
          end
          PH_SYM: begin
            if (n_r == SW'(NUM_STATES - 1)) begin
              if (o_r == '0 || acc_sum > best_r) begin
                best_nxt  = acc_sum;
                guess_nxt = 4'(o_r);
              end
              acc_nxt = '0;
              n_nxt   = '0;
              if (o_r == OW'(NUM_SYMBOLS - 1)) begin
                o_nxt  = '0;
                ph_nxt = PH_NUM;
              end else begin
                o_nxt = o_r + OW'(1);
              end
            end
          end
          default: begin
            num_we = 1'b1;
            if (n_r == SW'(NUM_STATES - 1)) begin
              n_nxt = '0;
              if (acc_sum == '0) begin
                imp_nxt = 1'b1;
                st_nxt  = ST_DONE;
              end else begin
                st_nxt = ST_DIV_RD;
              end
            end
          end
        endcase
      end
      ST_DIV_RD: st_nxt = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start = 1'b1;
        st_nxt    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          bel_we = 1'b1;
          if (n_r == SW'(NUM_STATES - 1)) begin
            st_nxt = ST_DONE;
          end else begin
            n_nxt  = n_r + SW'(1);
            st_nxt = ST_DIV_RD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  hmmf_frac_div #(
    .NW (MW),
    .TW (TW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_rd_r),
    .den   (acc_r),
    .stat  (div_stat),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign g_out = is_obs_r ? guess_r : 4'd0;
  assign hit_c = scored_r && (guess_r == obs_r);
  assign cnt_c = scored_r && (guess_r != 4'd0 || obs_r != 4'd0);
  assign agr_c = cnt_c && ((int'(guess_r) > HALF) == (int'(obs_r) > HALF));

  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    n_r     <= n_nxt;
    o_r     <= o_nxt;
    acc_r   <= acc_nxt;
    best_r  <= best_nxt;
    guess_r <= guess_nxt;
    imp_r   <= imp_nxt;
    prod_r  <= MW'(mx * my);
    if (in_fire) begin
      obs_r    <= in_ch.observed_symbol;
      obs_ok_r <= int'(in_ch.observed_symbol) < NUM_SYMBOLS;
      is_obs_r <= in_ch.opcode == OP_OBSERVE;
      scored_r <= (in_ch.opcode == OP_OBSERVE) && (cnt_r >= warm_r);
    end
    if (!rst_n) begin
      bel_vld_r     <= '0;
      cnt_r         <= '0;
      warm_r        <= WARMUP_RESET;
      out_ch.valid  <= 1'b0;
    end else begin
      if (bel_we) begin
        bel_vld_r[n_r] <= 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        warm_r <= cfg_ch.data;
      end
      if (in_fire && in_ch.opcode == OP_RESTART) begin
        cnt_r <= '0;
      end else if (in_fire && in_ch.opcode == OP_OBSERVE && cnt_r != 16'hFFFF) begin
        cnt_r <= cnt_r + 16'd1;
      end
      if (in_fire && in_ch.opcode != OP_RESTART && in_ch.opcode != OP_OBSERVE) begin
        out_ch.valid <= 1'b1;
      end else if (st_r == ST_DONE && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.opcode != OP_RESTART && in_ch.opcode != OP_OBSERVE) begin
      out_ch.predicted_symbol  <= 4'd0;
      out_ch.scored            <= 1'b0;
      out_ch.hit               <= 1'b0;
      out_ch.direction_counted <= 1'b0;
      out_ch.direction_agree   <= 1'b0;
      out_ch.impossible        <= 1'b0;
    end else if (st_r == ST_DONE && out_free) begin
      out_ch.predicted_symbol  <= g_out;
      out_ch.scored            <= scored_r;
      out_ch.hit               <= hit_c;
      out_ch.direction_counted <= cnt_c;
      out_ch.direction_agree   <= agr_c;
      out_ch.impossible        <= is_obs_r && imp_r;
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> st_r == ST_IDLE) else $error("ready outside idle");
  a_hit_scored: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> out_ch.scored) else $error("hit without score");
  a_agree_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.direction_agree |-> out_ch.direction_counted)
    else $error("agree without count");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV_WAIT |-> acc_r != '0) else $error("zero divisor");
`endif

endmodule
